>>> rtl/spq_pkg.sv
package spq_pkg;

    localparam int PRIO_W        = 16;
    localparam int DATA_W        = 32;
    localparam int OCC_W         = 5;
    localparam int DEFAULT_DEPTH = 16;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_DUP       = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_INS_SHIFT,
        S_INS_WRITE,
        S_DEL_SHIFT,
        S_HEAD,
        S_HEAD_WAIT
    } state_t;

endpackage

>>> rtl/sorted_priority_queue_core.sv
// sorted priority queue: up to DEPTH entries kept in one ram in descending priority order,
// priorities unique. a command is taken when start is high and busy is low; busy then stays
// high until the result. from acceptance to the done pulse the sequencer walks the ram one
// entry per cycle, first to find the slot and then to move the entries behind it, and reads
// the head back at the end. the result (status, head entry, occupancy) is shown for exactly
// one cycle with done high; the receiver cannot stall it, and a new command may be issued in
// that same cycle.
module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     cmd,
    input  logic [PRIO_W-1:0]        prio,
    input  logic signed [DATA_W-1:0] payload,
    output logic                     done,
    output logic [1:0]               status,
    output logic                     head_valid,
    output logic [PRIO_W-1:0]        head_prio,
    output logic signed [DATA_W-1:0] head_payload,
    output logic [OCC_W-1:0]         occupancy
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = PRIO_W + DATA_W;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       pos_reg, pos_next;
    logic [IW-1:0]       cur_reg, cur_next;
    logic                found_reg, found_next;
    status_t             status_reg, status_next;
    logic                done_reg, done_next;

    cmd_t                cmd_reg;
    logic [PRIO_W-1:0]   key_reg;
    logic [DATA_W-1:0]   word_reg;
    logic                head_valid_reg, head_valid_next;
    logic [PRIO_W-1:0]   head_prio_reg, head_prio_next;
    logic [DATA_W-1:0]   head_payload_reg, head_payload_next;

    logic                rd_en, wr_en;
    logic [IW-1:0]       rd_addr, wr_addr;
    logic [EW-1:0]       rd_data, wr_data;
    logic [PRIO_W-1:0]   rd_prio;

    logic [CW-1:0]       scan_p1, count_m1, pos_p1, cur_p2;
    logic                accept;

    spq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_prio  = rd_data[EW-1:DATA_W];
    assign scan_p1  = CW'(cur_reg) + CW'(1);
    assign cur_p2   = CW'(cur_reg) + CW'(2);
    assign count_m1 = count_reg - CW'(1);
    assign pos_p1   = pos_reg + CW'(1);
    assign accept   = start && (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            pos_reg    <= '0;
            cur_reg    <= '0;
            found_reg  <= 1'b0;
            status_reg <= ST_DONE;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
            cur_reg    <= cur_next;
            found_reg  <= found_next;
            status_reg <= status_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd_t'(cmd);
            key_reg  <= prio;
            word_reg <= payload;
        end
        head_valid_reg   <= head_valid_next;
        head_prio_reg    <= head_prio_next;
        head_payload_reg <= head_payload_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        pos_next          = pos_reg;
        cur_next          = cur_reg;
        found_next        = found_reg;
        status_next       = status_reg;
        done_next         = 1'b0;
        head_valid_next   = head_valid_reg;
        head_prio_next    = head_prio_reg;
        head_payload_next = head_payload_reg;
        rd_en             = 1'b0;
        rd_addr           = '0;
        wr_en             = 1'b0;
        wr_addr           = cur_reg;
        wr_data           = rd_data;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    status_next = ST_DONE;
                    if (count_reg == '0)
                    begin
                        pos_next   = '0;
                        found_next = 1'b0;
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        cur_next   = '0;
                        state_next = S_SEARCH;
                    end
                end
            end

            // rd_data holds the entry at cur_reg; the next read goes out in the same cycle
            S_SEARCH:
            begin
                if (rd_prio > key_reg)
                begin
                    if (scan_p1 < count_reg)
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = cur_reg + IW'(1);
                        cur_next = cur_reg + IW'(1);
                    end
                    else
                    begin
                        pos_next   = count_reg;
                        found_next = 1'b0;
                        state_next = S_DECIDE;
                    end
                end
                else
                begin
                    pos_next   = CW'(cur_reg);
                    found_next = (rd_prio == key_reg);
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (cmd_reg == CMD_INSERT)
                begin
                    if (found_reg)
                    begin
                        status_next = ST_DUP;
                        state_next  = S_HEAD;
                    end
                    else if (count_reg == FULL_COUNT)
                    begin
                        status_next = ST_FULL;
                        state_next  = S_HEAD;
                    end
                    else if (pos_reg < count_reg)
                    begin
                        // move the tail up by one, last entry first
                        rd_en      = 1'b1;
                        rd_addr    = count_m1[IW-1:0];
                        cur_next   = count_reg[IW-1:0];
                        state_next = S_INS_SHIFT;
                    end
                    else
                    begin
                        state_next = S_INS_WRITE;
                    end
                end
                else
                begin
                    if (!found_reg)
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_HEAD;
                    end
                    else if (pos_p1 < count_reg)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = pos_p1[IW-1:0];
                        cur_next   = pos_reg[IW-1:0];
                        state_next = S_DEL_SHIFT;
                    end
                    else
                    begin
                        count_next = count_m1;
                        state_next = S_HEAD;
                    end
                end
            end

            S_INS_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = cur_reg;
                wr_data = rd_data;
                if (CW'(cur_reg) > pos_p1)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = cur_reg - IW'(2);
                    cur_next = cur_reg - IW'(1);
                end
                else
                begin
                    state_next = S_INS_WRITE;
                end
            end

            S_INS_WRITE:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg[IW-1:0];
                wr_data    = {key_reg, word_reg};
                count_next = count_reg + CW'(1);
                state_next = S_HEAD;
            end

            // pull the tail down by one over the deleted slot
            S_DEL_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = cur_reg;
                wr_data = rd_data;
                if (cur_p2 < count_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = cur_reg + IW'(2);
                    cur_next = cur_reg + IW'(1);
                end
                else
                begin
                    count_next = count_m1;
                    state_next = S_HEAD;
                end
            end

            S_HEAD:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = S_HEAD_WAIT;
            end

            S_HEAD_WAIT:
            begin
                done_next       = 1'b1;
                head_valid_next = (count_reg != '0);
                if (count_reg != '0)
                begin
                    head_prio_next    = rd_prio;
                    head_payload_next = rd_data[DATA_W-1:0];
                end
                else
                begin
                    head_prio_next    = '0;
                    head_payload_next = '0;
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign head_valid   = head_valid_reg;
    assign head_prio    = head_prio_reg;
    assign head_payload = $signed(head_payload_reg);
    assign occupancy    = OCC_W'(count_reg);

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_done_from_head: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_HEAD_WAIT))
        else $error("result strobe without head readback");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count above depth");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("ram read and write at the same slot");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(busy))
        else $error("entry count changed while idle");

endmodule

>>> rtl/spq_ram.sv
module spq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> verif/spq_checker.sv
`timescale 1ns / 100ps

module spq_checker
    import spq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic                     cmd,
    input  logic [PRIO_W-1:0]        prio,
    input  logic signed [DATA_W-1:0] payload,
    input  logic                     done,
    input  logic [1:0]               status,
    input  logic                     head_valid,
    input  logic [PRIO_W-1:0]        head_prio,
    input  logic signed [DATA_W-1:0] head_payload,
    input  logic [OCC_W-1:0]         occupancy,
    output int                       mismatches,
    output int                       outstanding,
    output int                       seen_done,
    output int                       seen_dup,
    output int                       seen_full,
    output int                       seen_absent,
    output int                       peak_fill
);

    typedef struct packed {
        status_t                  status;
        logic                     head_valid;
        logic [PRIO_W-1:0]        head_prio;
        logic signed [DATA_W-1:0] head_payload;
        logic [OCC_W-1:0]         occupancy;
    } spq_result_t;

    // shadow of the sorted store, highest priority in slot 0
    logic [PRIO_W-1:0]        shadow_prio [DEPTH];
    logic signed [DATA_W-1:0] shadow_data [DEPTH];
    int                       fill;

    spq_result_t pending_results[$];

    function automatic spq_result_t apply_command(cmd_t op, logic [PRIO_W-1:0] key,
                                                  logic signed [DATA_W-1:0] word);
        int          pos;
        int          k;
        spq_result_t r;
        pos = 0;
        while (pos < fill && shadow_prio[pos] > key)
            pos++;
        r.status = ST_DONE;
        if (op == CMD_INSERT)
        begin
            if (pos < fill && shadow_prio[pos] == key)
                r.status = ST_DUP;
            else if (fill >= DEPTH)
                r.status = ST_FULL;
            else
            begin
                for (k = fill; k > pos; k--)
                begin
                    shadow_prio[k] = shadow_prio[k-1];
                    shadow_data[k] = shadow_data[k-1];
                end
                shadow_prio[pos] = key;
                shadow_data[pos] = word;
                fill++;
            end
        end
        else
        begin
            if (pos < fill && shadow_prio[pos] == key)
            begin
                for (k = pos; k + 1 < fill; k++)
                begin
                    shadow_prio[k] = shadow_prio[k+1];
                    shadow_data[k] = shadow_data[k+1];
                end
                fill--;
            end
            else
                r.status = ST_NOT_FOUND;
        end
        r.head_valid   = (fill > 0);
        r.head_prio    = (fill > 0) ? shadow_prio[0] : '0;
        r.head_payload = (fill > 0) ? shadow_data[0] : '0;
        r.occupancy    = OCC_W'(fill);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        spq_result_t want;
        spq_result_t got;
        if (!rst_n)
        begin
            fill = 0;
            pending_results.delete();
            outstanding = 0;
            mismatches  = 0;
            seen_done   = 0;
            seen_dup    = 0;
            seen_full   = 0;
            seen_absent = 0;
            peak_fill   = 0;
        end
        else
        begin
            // result of an older transaction may land on the edge that takes a new one
            if (done)
            begin
                got = {status_t'(status), head_valid, head_prio, head_payload, occupancy};
                if (pending_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display({"%0t: result with nothing pending:",
                                  " st=%0d hv=%0b hp=%h hd=%h occ=%0d"},
                                 $realtime, status, head_valid, head_prio, head_payload,
                                 occupancy);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                            $display({"%0t: mismatch exp st=%0d hv=%0b hp=%h hd=%h occ=%0d",
                                      " got st=%0d hv=%0b hp=%h hd=%h occ=%0d"},
                                     $realtime, want.status, want.head_valid, want.head_prio,
                                     want.head_payload, want.occupancy, got.status,
                                     got.head_valid, got.head_prio, got.head_payload,
                                     got.occupancy);
                        mismatches++;
                    end
                    case (want.status)
                        ST_DONE:      seen_done++;
                        ST_DUP:       seen_dup++;
                        ST_FULL:      seen_full++;
                        ST_NOT_FOUND: seen_absent++;
                        default:      ;
                    endcase
                end
            end
            if (start && !busy)
            begin
                pending_results.push_back(apply_command(cmd_t'(cmd), prio, payload));
                if (fill > peak_fill)
                    peak_fill = fill;
            end
            outstanding = pending_results.size();
        end
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import spq_pkg::*;

    localparam int DEPTH       = DEFAULT_DEPTH;
    localparam int PHASE_ITEMS = 475;
    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_SIZE   = 20;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     cmd;
    logic [PRIO_W-1:0]        prio;
    logic signed [DATA_W-1:0] payload;
    logic                     done;
    logic [1:0]               status;
    logic                     head_valid;
    logic [PRIO_W-1:0]        head_prio;
    logic signed [DATA_W-1:0] head_payload;
    logic [OCC_W-1:0]         occupancy;

    int mismatches;
    int outstanding;
    int seen_done;
    int seen_dup;
    int seen_full;
    int seen_absent;
    int peak_fill;
    int cycles = 0;
    int issued = 0;
    int idle_pct;

    logic [PRIO_W-1:0] key_pool [POOL_SIZE];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    sorted_priority_queue_core #(.DEPTH(DEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .prio         (prio),
        .payload      (payload),
        .done         (done),
        .status       (status),
        .head_valid   (head_valid),
        .head_prio    (head_prio),
        .head_payload (head_payload),
        .occupancy    (occupancy)
    );

    spq_checker #(.DEPTH(DEPTH)) chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .prio         (prio),
        .payload      (payload),
        .done         (done),
        .status       (status),
        .head_valid   (head_valid),
        .head_prio    (head_prio),
        .head_payload (head_payload),
        .occupancy    (occupancy),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .seen_done    (seen_done),
        .seen_dup     (seen_dup),
        .seen_full    (seen_full),
        .seen_absent  (seen_absent),
        .peak_fill    (peak_fill)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending", cycles, outstanding);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the transaction is taken
    task automatic issue(cmd_t op, logic [PRIO_W-1:0] key, logic signed [DATA_W-1:0] word);
        start   <= 1'b1;
        cmd     <= op;
        prio    <= key;
        payload <= word;
        do
            @(posedge clk);
        while (busy);
        issued++;
        @(negedge clk);
    endtask

    // start low with junk on the fields through the busy period, then idle each
    // ready cycle at the given rate
    task automatic sender_gap(int pct);
        if (pct > 0)
        begin
            start   <= 1'b0;
            cmd     <= 1'($urandom_range(1));
            prio    <= PRIO_W'($urandom);
            payload <= $urandom;
            while (busy)
                @(negedge clk);
            while ($urandom_range(99) < pct)
                @(negedge clk);
        end
    endtask

    task automatic refill_pool();
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = PRIO_W'($urandom);
        if ($urandom_range(3) == 0)
            key_pool[0] = '0;
        if ($urandom_range(3) == 0)
            key_pool[1] = '1;
    endtask

    task automatic random_phase(int pct);
        int   left;
        int   burst;
        int   ins_pct;
        cmd_t op;
        logic [PRIO_W-1:0] key;
        left = PHASE_ITEMS;
        while (left > 0)
        begin
            // bursts lean toward filling, churning or draining the queue
            burst = $urandom_range(8, 40);
            case ($urandom_range(2))
                0:       ins_pct = 85;
                1:       ins_pct = 50;
                default: ins_pct = 15;
            endcase
            if ($urandom_range(2) == 0)
                refill_pool();
            while (burst > 0 && left > 0)
            begin
                op  = ($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_DELETE;
                key = ($urandom_range(9) == 0) ? PRIO_W'($urandom)
                                               : key_pool[$urandom_range(POOL_SIZE - 1)];
                issue(op, key, $urandom);
                sender_gap(pct);
                burst--;
                left--;
            end
        end
    endtask

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        cmd     = 1'b0;
        prio    = '0;
        payload = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty, head changes, duplicates, full, deletes at head, middle and tail
        issue(CMD_DELETE, 16'h0000, 32'h1234_5678);
        issue(CMD_INSERT, 16'h8000, 32'h7FFF_FFFF);
        issue(CMD_INSERT, 16'hFFFF, 32'h8000_0000);
        issue(CMD_INSERT, 16'h0000, 32'hFFFF_FFFF);
        issue(CMD_INSERT, 16'h8000, 32'h0000_0000);
        issue(CMD_DELETE, 16'h1234, 32'h5555_AAAA);
        issue(CMD_DELETE, 16'hFFFF, 32'h0000_0000);
        for (int i = 1; i <= 14; i++)
            issue(CMD_INSERT, PRIO_W'(i * 16'h1111), $urandom);
        issue(CMD_INSERT, 16'h0001, 32'hAAAA_5555);
        issue(CMD_INSERT, 16'h8000, 32'h0F0F_0F0F);
        issue(CMD_DELETE, 16'h0000, 32'hFFFF_FFFF);
        issue(CMD_DELETE, 16'h8000, 32'h0000_0000);

        refill_pool();
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 38 : (phase == 1) ? 71 : 0;
            random_phase(idle_pct);
        end
        start <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("%0d commands sent over three sender idle profiles, peak occupancy %0d of %0d",
                 issued, peak_fill, DEPTH);
        $display("results: %0d done, %0d duplicate, %0d full, %0d absent key",
                 seen_done, seen_dup, seen_full, seen_absent);
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> sim.f
rtl/spq_pkg.sv
rtl/spq_ram.sv
rtl/sorted_priority_queue_core.sv
verif/spq_checker.sv
verif/tb.sv
